// ----- hw/rtl/assert_macros.svh -----
// Concurrent assertion helpers shared by the RTL.
// Synthesis builds see empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check a property on every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_CLK_RST(label, clk, rst, prop)
`define ASSERT_CLK(label, clk, prop)

`endif

`endif

// ----- hw/rtl/cwse_pkg.sv -----
package cwse_pkg;

  localparam int unsigned CRC_W = 32;
  localparam logic [CRC_W-1:0] CRC_POLY  = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_RESET = 32'hFFFF_FFFF;
  localparam logic [CRC_W-1:0] CRC_TOP   = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        first_word;
    logic        last_word;
  } cwse_req_t;

  typedef struct packed {
    logic [31:0] crc_out;
    logic        crc_final;
  } cwse_rsp_t;

  // Column i of the 32-shift CRC matrix: the register after shifting in
  // a lone one at bit i. Evaluated at elaboration only.
  function automatic logic [CRC_W-1:0][CRC_W-1:0] crc_columns();
    logic [CRC_W-1:0][CRC_W-1:0] cols;
    logic [CRC_W-1:0]            c;
    for (int i = 0; i < CRC_W; i++) begin
      c = '0;
      c[i] = 1'b1;
      for (int k = 0; k < CRC_W; k++) begin
        if ((c & CRC_TOP) != '0) begin
          c = (c << 1) ^ CRC_POLY;
        end else begin
          c = c << 1;
        end
      end
      cols[i] = c;
    end
    return cols;
  endfunction

  localparam logic [CRC_W-1:0][CRC_W-1:0] CRC_COLS = crc_columns();

endpackage

// ----- hw/rtl/crc32_word_stream_engine_core.sv -----
// Channel  | Direction | Handshake            | Payload
// request  | in        | in_valid / in_ready  | in_req  (cwse_req_t)
// result   | out       | out_valid / out_ready| out_rsp (cwse_rsp_t)
// config   | in        | cfg_wr_en            | cfg_wr_data (init_value)
//
// One request per cycle sustained while results are taken; an accepted
// request is held in the input register, then its result is loaded into
// the result register when that is free or being emptied.
// The combinational XOR network folding 32 bits into crc_reg sets the rate.
// Synchronous active-high rst clears both stage valids and sets crc_reg and
// init_value to all ones. A stalled result holds in the result register
// while one further request waits in the input register.
`include "assert_macros.svh"

module crc32_word_stream_engine_core
  import cwse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  cwse_req_t   in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output cwse_rsp_t   out_rsp,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic             s1_valid;
  cwse_req_t        s1_req;
  logic [CRC_W-1:0] init_value;
  logic [CRC_W-1:0] crc_reg;
  logic [CRC_W-1:0] crc_next;
  logic [CRC_W-1:0] word_masked;
  logic [CRC_W-1:0] crc_base;
  logic [CRC_W-1:0] fold;
  logic             advance;

  // Move the held request into the result register when that is free
  // or being emptied this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Drop the missing upper bytes of a tail word.
  always_comb begin
    case (s1_req.byte_count)
      3'd1:    word_masked = {24'h0, s1_req.data_word[7:0]};
      3'd2:    word_masked = {16'h0, s1_req.data_word[15:0]};
      3'd3:    word_masked = {8'h0, s1_req.data_word[23:0]};
      default: word_masked = s1_req.data_word;
    endcase
  end

  // Reload from init_value on a first word, then apply the 32-shift
  // matrix: each set bit contributes its precomputed column.
  always_comb begin
    crc_base = s1_req.first_word ? init_value : crc_reg;
    fold     = crc_base ^ word_masked;
    crc_next = '0;
    for (int i = 0; i < CRC_W; i++) begin
      if (fold[i]) begin
        crc_next = crc_next ^ CRC_COLS[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_value <= CRC_RESET;
    end else if (cfg_wr_en) begin
      init_value <= cfg_wr_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req <= in_req;
    end
  end

  // Running CRC advances together with the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg <= CRC_RESET;
    end else if (advance) begin
      crc_reg <= crc_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp.crc_out   <= crc_next;
      out_rsp.crc_final <= s1_req.last_word;
    end
  end

  `ASSERT_CLK_RST(a_advance_fills_out, clk, rst, advance |=> out_valid)
  `ASSERT_CLK_RST(a_out_matches_state, clk, rst, out_valid |-> out_rsp.crc_out == crc_reg)
  `ASSERT_CLK_RST(a_full_stall_blocks, clk, rst, (s1_valid && out_valid && !out_ready) |-> !in_ready)
  `ASSERT_CLK(a_reset_state, clk, rst |=> (crc_reg == CRC_RESET) && !out_valid && !s1_valid)

endmodule

// ----- tb/tb_crc32_word_stream_engine_core.sv -----
module tb_crc32_word_stream_engine_core
  import cwse_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cwse_req_t   in_req = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  cwse_rsp_t   out_rsp;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  // Requests waiting to be driven, and the results owed by the block
  cwse_req_t   req_backlog[$];
  cwse_rsp_t   crc_expected_q[$];

  // Own copy of the running CRC and of the initial-value register
  logic [31:0] crc_model = CRC_RESET;
  logic [31:0] init_model = CRC_RESET;

  bit          quiet_mode = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          fail_count = 0;
  int          cycle_count = 0;

  crc32_word_stream_engine_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rsp    (out_rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Shift a whole 32-bit word, MSB first, through the CRC register
  function automatic logic [31:0] next_crc(logic [31:0] crc, logic [31:0] word);
    logic [31:0] c;
    c = crc ^ word;
    for (int k = 0; k < 32; k++) begin
      if (c[31]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // Work out the result of one accepted request and queue it
  task automatic fold_request(cwse_req_t req);
    logic [31:0] word;
    cwse_rsp_t   rsp;
    word = req.data_word;
    // Zero the missing upper bytes of a tail word; any other count
    // (zero or above four included) absorbs the full word
    case (req.byte_count)
      3'd1: word = word & 32'h0000_00FF;
      3'd2: word = word & 32'h0000_FFFF;
      3'd3: word = word & 32'h00FF_FFFF;
      default: ;
    endcase
    if (req.first_word) begin
      crc_model = init_model;
    end
    crc_model = next_crc(crc_model, word);
    rsp.crc_out = crc_model;
    rsp.crc_final = req.last_word;
    crc_expected_q.push_back(rsp);
  endtask

  function automatic int draw_wait();
    if (quiet_mode) begin
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  task automatic push_req(logic [31:0] data, logic [2:0] count, logic first, logic last);
    cwse_req_t req;
    req.data_word = data;
    req.byte_count = count;
    req.first_word = first;
    req.last_word = last;
    req_backlog.push_back(req);
  endtask

  function automatic logic [31:0] draw_word();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed messages with random content, plus some noise
  // requests with arbitrary counts and flags
  task automatic queue_random(int n_items);
    int issued;
    int len;
    issued = 0;
    while (issued < n_items) begin
      if ($urandom_range(0, 9) < 8) begin
        len = $urandom_range(1, 8);
        for (int w = 0; w < len; w++) begin
          push_req(draw_word(),
                   (w == len - 1) ? 3'($urandom_range(1, 4)) : 3'd4,
                   w == 0, w == len - 1);
        end
        issued += len;
      end else begin
        push_req(draw_word(), 3'($urandom_range(0, 7)),
                 1'($urandom), 1'($urandom));
        issued++;
      end
    end
  endtask

  // Block until every request is driven and every result has come back
  task automatic wait_idle();
    @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || crc_expected_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_init(logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    init_model = value;
    @(negedge clk);
  endtask

  // Driver: present a request, hold it until accepted, then idle for the
  // gap drawn when it was loaded
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        fold_request(in_req);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          in_req <= req_backlog.pop_front();
          in_valid <= 1'b1;
          gap_left = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: take each result, compare against the oldest expectation,
  // then stall for a drawn number of cycles
  always @(posedge clk) begin
    cwse_rsp_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (crc_expected_q.size() == 0) begin
          $display("%0t: unexpected result crc_out=%08h crc_final=%0b",
                   $realtime, out_rsp.crc_out, out_rsp.crc_final);
          fail_count++;
        end else begin
          want = crc_expected_q.pop_front();
          if (out_rsp.crc_out !== want.crc_out) begin
            $display("%0t: crc_out mismatch expected %08h actual %08h",
                     $realtime, want.crc_out, out_rsp.crc_out);
            fail_count++;
          end
          if (out_rsp.crc_final !== want.crc_final) begin
            $display("%0t: crc_final mismatch expected %0b actual %0b",
                     $realtime, want.crc_final, out_rsp.crc_final);
            fail_count++;
          end
        end
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [31:0] init_set[6];
    init_set[0] = 32'h0000_0000;
    init_set[1] = 32'hFFFF_FFFF;
    init_set[2] = $urandom;
    init_set[3] = 32'h8000_0000;
    init_set[4] = 32'h0000_0001;
    init_set[5] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: run from the reset value with no first word, carry on
    // past a last word, then one-word messages across every count
    push_req(32'h0000_0000, 3'd4, 1'b0, 1'b0);
    push_req(32'hFFFF_FFFF, 3'd4, 1'b0, 1'b1);
    push_req(32'h1234_5678, 3'd4, 1'b0, 1'b0);
    push_req(32'hDEAD_BEEF, 3'd4, 1'b1, 1'b1);
    for (int c = 0; c < 8; c++) begin
      push_req(32'hFFFF_FFFF, 3'(c), 1'b1, 1'b1);
    end
    push_req(32'h8000_0000, 3'd4, 1'b1, 1'b0);
    push_req(32'h0000_0001, 3'd4, 1'b0, 1'b0);
    push_req(32'h7FFF_FFFF, 3'd4, 1'b0, 1'b0);
    push_req(32'hA5A5_A5A5, 3'd3, 1'b0, 1'b1);
    push_req(32'hFFFF_FFFF, 3'd2, 1'b1, 1'b1);
    push_req(32'hFFFF_FFFF, 3'd1, 1'b1, 1'b1);
    wait_idle();

    // Random phases, one initial value each; run one with no idling
    for (int p = 0; p < 6; p++) begin
      repeat (DRAIN_CYCLES) @(negedge clk);
      write_init(init_set[p]);
      quiet_mode = (p == 2);
      queue_random(100);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && crc_expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
